[hw/rtl/wwm_pkg.sv]
// ----------------------------------------------------------------------------
// wwm_pkg
// Shared constants, types and helpers for the winnowing window minimum block.
// ----------------------------------------------------------------------------
package wwm_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int HASH_W     = 64;
    localparam int WIN_W      = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [WIN_W-1:0] WIN_RESET       = WIN_W'(28);
    localparam logic             REG_WINDOW_SIZE = 1'b0;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic write;
        logic init;
        logic issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last_issue;
        logic out_free;
    } t_sts;

    // zero means one, anything above the store depth is clamped
    function automatic t_cnt eff_window(input logic [WIN_W-1:0] ws);
        t_cnt w;
        if (ws == '0) begin
            w = t_cnt'(1);
        end else if (int'(ws) > MAX_WINDOW) begin
            w = t_cnt'(MAX_WINDOW);
        end else begin
            w = t_cnt'(ws);
        end
        return w;
    endfunction

endpackage

[hw/rtl/wwm_ram.sv]
// ----------------------------------------------------------------------------
// wwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/wwm_datapath.sv]
// ----------------------------------------------------------------------------
// wwm_datapath
// Window store, fill count, scan pointer, running minimum and result register.
// ----------------------------------------------------------------------------
module wwm_datapath import wwm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    output t_sts  o_sts,
    input  t_hash i_hash_value,
    input  logic  i_document_start,
    input  t_cnt  i_window,
    input  logic  i_out_stall,
    output logic  o_out_valid,
    output t_hash o_fingerprint
);

    t_addr r_wr_pos;
    t_addr r_rd_pos;
    t_cnt  r_fill;
    t_cnt  r_cnt;
    logic  r_rd_vld;
    t_hash r_min;
    logic  r_out_valid;
    t_hash r_fingerprint;

    t_addr n_wr_pos;
    t_addr n_rd_pos;
    t_cnt  n_fill;
    t_hash w_rdata;
    t_hash w_fold;
    t_hash w_best;

    wwm_ram #(
        .WIDTH (HASH_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wr_pos),
        .i_wdata (i_hash_value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_pos),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (i_document_start) begin
            n_fill = t_cnt'(1);
        end else if (r_fill == t_cnt'(MAX_WINDOW)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + t_cnt'(1);
        end
        n_wr_pos = (r_wr_pos == t_addr'(MAX_WINDOW - 1)) ? '0 : r_wr_pos + t_addr'(1);
        n_rd_pos = (r_rd_pos == '0) ? t_addr'(MAX_WINDOW - 1) : r_rd_pos - t_addr'(1);
        w_fold   = (w_rdata < r_min) ? w_rdata : r_min;
        w_best   = r_rd_vld ? w_fold : r_min;
    end

    assign o_sts.emit       = (n_fill >= i_window);
    assign o_sts.last_issue = (r_cnt == t_cnt'(1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_wr_pos <= n_wr_pos;
                r_fill   <= n_fill;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_rd_pos <= r_wr_pos;
            r_cnt    <= i_window;
            r_min    <= '1;
        end else begin
            if (i_cmd.issue) begin
                r_rd_pos <= n_rd_pos;
                r_cnt    <= r_cnt - t_cnt'(1);
            end
            if (r_rd_vld) begin
                r_min <= w_fold;
            end
        end
        if (i_cmd.load_out) begin
            r_fingerprint <= w_best;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fingerprint = r_fingerprint;

endmodule

[hw/rtl/wwm_ctrl.sv]
// ----------------------------------------------------------------------------
// wwm_ctrl
// Sequencer: takes a request, scans the window one entry a cycle, hands off.
// ----------------------------------------------------------------------------
module wwm_ctrl import wwm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.write = i_in_valid;
                if (i_in_valid && i_sts.emit) begin
                    o_cmd.init = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

[hw/rtl/winnowing_window_minimum.sv]
// ----------------------------------------------------------------------------
// winnowing_window_minimum
// Sliding window minimum over a stream of 64-bit k-gram hashes.
// ----------------------------------------------------------------------------
// a request that gives no fingerprint is written to the store and the block stays idle
// a request that gives one: the window scan over the single store read port
// reads w entries, newest first, one entry a cycle (w = effective window size),
// then the fingerprint is loaded once the output is free; no request is taken until then
// reset: synchronous, active low; window_size returns to 28, fill count and
// write pointer clear, store contents stay undefined until written
module winnowing_window_minimum import wwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [HASH_W-1:0]  i_hash_value,
    input  logic               i_document_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [HASH_W-1:0]  o_fingerprint,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [WIN_W-1:0] r_window_size;
    t_cmd             w_cmd;
    t_sts             w_sts;
    t_cnt             w_window;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[WIN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_SIZE) begin
            prdata = PDATA_W'(r_window_size);
        end
    end

    assign w_window = eff_window(r_window_size);

    wwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wwm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_hash_value     (i_hash_value),
        .i_document_start (i_document_start),
        .i_window         (w_window),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_fingerprint    (o_fingerprint)
    );

    // no request taken while the window is being scanned
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> (o_in_stall && !w_cmd.write))
        else $error("request accepted during scan");

    // a pending fingerprint is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("fingerprint overwritten");

    // a loaded fingerprint shows up next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_out_valid)
        else $error("fingerprint load lost");

endmodule
